// ----- rtl/wsa_pkg.sv -----
// shared types and constants for the weighted share allocator
package wsa_pkg;

    localparam int MaxItems = 16;
    localparam int IdxW     = $clog2(MaxItems);
    localparam int CntW     = $clog2(MaxItems + 1);
    localparam int AmtW     = 24;
    localparam int WgtW     = 16;
    localparam int WsumW    = WgtW + CntW;
    localparam int SsumW    = AmtW + CntW;
    localparam int RemW     = AmtW + 1;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 24;

    localparam logic [CfgIdxW-1:0] CfgTotal  = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgFloors = 1'd1;

    typedef struct packed {
        logic [AmtW-1:0] explicit_amount;
        logic [WgtW-1:0] item_weight;
        logic [AmtW-1:0] floor_amount;
        logic            last_item;
    } t_in_beat;

    typedef struct packed {
        logic [AmtW-1:0] item_amount;
        logic            last_result;
        logic            items_dropped;
    } t_out_beat;

    // divider request and response
    typedef struct packed {
        logic                     start;
        logic [SsumW+AmtW-1:0]    dividend;
        logic [SsumW-1:0]         divisor;
    } t_div_req;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic [SsumW+AmtW-1:0]    quotient;
    } t_div_rsp;

endpackage

// ----- rtl/wsa_div.sv -----
// restoring divider, one quotient bit per cycle
module wsa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wsa_pkg::t_div_req i_req,
    output wsa_pkg::t_div_rsp o_rsp
);

    localparam int NW = wsa_pkg::SsumW + wsa_pkg::AmtW;
    localparam int DW = wsa_pkg::SsumW;
    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0] r_quo, n_quo;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_dvs, n_dvs;
    logic [SW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    always_comb begin
        shifted = {r_rem[DW-1:0], r_quo[NW-1]};
        diff    = shifted - {1'b0, r_dvs};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_cnt  = SW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[DW]) begin
                n_rem = diff;
                n_quo = {r_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - SW'(1);
            if (r_cnt == SW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- rtl/weighted_share_allocator.sv -----
// weighted share allocator top level
// Items are loaded one per cycle until a beat with last_item set. The block then
// stalls its input and resolves the set with one shared bit-serial divider of
// 53 steps: a sum pass over the N items, one division per flexible item for the
// weighted share, and with floors on and a nonzero share sum and remainder a
// second division per flexible item for rescaling; a fixed item needs no
// division. Results leave one per cycle through an output register while the
// output is not stalled.
module weighted_share_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  wsa_pkg::t_in_beat                 i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output wsa_pkg::t_out_beat                o_data,
    input  logic                              i_cfg_we,
    input  logic [wsa_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [wsa_pkg::CfgDataW-1:0]      i_cfg_data
);

    localparam int IW = wsa_pkg::IdxW;
    localparam int CW = wsa_pkg::CntW;
    localparam int AW = wsa_pkg::AmtW;
    localparam int WW = wsa_pkg::WgtW;
    localparam int NW = wsa_pkg::SsumW + wsa_pkg::AmtW;
    localparam int SW = wsa_pkg::SsumW;

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_SUM   = 7'b0000010,
        ST_SHARE = 7'b0000100,
        ST_SWAIT = 7'b0001000,
        ST_SCALE = 7'b0010000,
        ST_CWAIT = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    logic [AW-1:0] mem_exp   [wsa_pkg::MaxItems];
    logic [WW-1:0] mem_wgt   [wsa_pkg::MaxItems];
    logic [AW-1:0] mem_flr   [wsa_pkg::MaxItems];
    logic [AW-1:0] mem_share [wsa_pkg::MaxItems];

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_idx, n_idx;
    logic                    r_dropped, n_dropped;
    logic [AW:0]             r_fixed, n_fixed;
    logic [wsa_pkg::WsumW-1:0] r_wsum, n_wsum;
    logic [SW-1:0]           r_ssum, n_ssum;
    logic [AW-1:0]           r_total;
    logic                    r_floors;
    logic                    r_ovalid, n_ovalid;
    wsa_pkg::t_out_beat      r_odata, n_odata;

    logic [AW-1:0]           rd_exp, rd_flr, rd_share;
    logic [WW-1:0]           rd_wgt;
    logic [WW-1:0]           w_eff;
    logic [AW-1:0]           rem;
    logic                    share_we;
    logic [AW-1:0]           share_wd;
    logic                    out_free;
    logic                    in_acc;
    logic [AW+WW-1:0]        prod_w;
    logic [2*AW-1:0]         prod_s;
    logic [NW-1:0]           q_sat;
    logic [AW-1:0]           sh_val;
    logic [IW-1:0]           ai;
    wsa_pkg::t_div_req       div_req;
    wsa_pkg::t_div_rsp       div_rsp;

    assign ai       = r_idx[IW-1:0];
    assign rd_exp   = mem_exp[ai];
    assign rd_wgt   = mem_wgt[ai];
    assign rd_flr   = mem_flr[ai];
    assign rd_share = mem_share[ai];
    assign w_eff    = (rd_wgt != '0) ? rd_wgt : WW'(1);
    assign rem      = (r_fixed >= {1'b0, r_total}) ? '0 : AW'({1'b0, r_total} - r_fixed);
    assign out_free = !r_ovalid || !i_stall;
    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_LOAD);
    assign prod_w   = rem * w_eff;
    assign prod_s   = rd_share * rem;
    assign q_sat    = div_rsp.quotient;

    wsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_dropped = r_dropped;
        n_fixed   = r_fixed;
        n_wsum    = r_wsum;
        n_ssum    = r_ssum;
        n_ovalid  = r_ovalid && i_stall;
        n_odata   = r_odata;
        share_we  = 1'b0;
        share_wd  = '0;
        div_req   = '0;
        sh_val    = AW'(q_sat);
        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (r_count < CW'(wsa_pkg::MaxItems)) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_data.last_item) begin
                        n_state = ST_SUM;
                        n_idx   = '0;
                        n_fixed = '0;
                        n_wsum  = '0;
                        n_ssum  = '0;
                    end
                end
            end
            ST_SUM: begin
                if (rd_exp != '0) begin
                    n_fixed = r_fixed + (AW+1)'(rd_exp);
                    if (n_fixed[AW]) n_fixed = {1'b1, {AW{1'b0}}};
                end else begin
                    n_wsum = r_wsum + wsa_pkg::WsumW'(w_eff);
                end
                n_idx = r_idx + CW'(1);
                if (r_idx + CW'(1) == r_count) begin
                    n_idx   = '0;
                    n_state = ST_SHARE;
                end
            end
            ST_SHARE: begin
                if (rd_exp != '0) begin
                    share_we = 1'b1;
                    share_wd = rd_exp;
                    n_idx    = r_idx + CW'(1);
                    if (r_idx + CW'(1) == r_count) begin
                        n_idx   = '0;
                        n_state = (r_floors && n_ssum != '0 && rem != '0) ? ST_SCALE : ST_EMIT;
                    end
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = NW'(prod_w);
                    div_req.divisor  = SW'(r_wsum);
                    n_state          = ST_SWAIT;
                end
            end
            ST_SWAIT: begin
                if (div_rsp.done) begin
                    if (r_floors && {{(NW-AW){1'b0}}, rd_flr} > q_sat) sh_val = rd_flr;
                    share_we = 1'b1;
                    share_wd = sh_val;
                    n_ssum   = r_ssum + SW'(sh_val);
                    n_idx    = r_idx + CW'(1);
                    n_state  = ST_SHARE;
                    if (r_idx + CW'(1) == r_count) begin
                        n_idx   = '0;
                        n_state = (r_floors && n_ssum != '0 && rem != '0) ? ST_SCALE : ST_EMIT;
                    end
                end
            end
            ST_SCALE: begin
                if (rd_exp != '0) begin
                    n_idx = r_idx + CW'(1);
                    if (r_idx + CW'(1) == r_count) begin
                        n_idx   = '0;
                        n_state = ST_EMIT;
                    end
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = NW'(prod_s);
                    div_req.divisor  = r_ssum;
                    n_state          = ST_CWAIT;
                end
            end
            ST_CWAIT: begin
                if (div_rsp.done) begin
                    share_we = 1'b1;
                    share_wd = AW'(q_sat);
                    n_idx    = r_idx + CW'(1);
                    n_state  = ST_SCALE;
                    if (r_idx + CW'(1) == r_count) begin
                        n_idx   = '0;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata.item_amount   = rd_share;
                    n_odata.last_result   = (r_idx + CW'(1) == r_count);
                    n_odata.items_dropped = r_dropped;
                    n_idx = r_idx + CW'(1);
                    if (r_idx + CW'(1) == r_count) begin
                        n_state   = ST_LOAD;
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_idx     = '0;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && r_count < CW'(wsa_pkg::MaxItems)) begin
            mem_exp[r_count[IW-1:0]] <= i_data.explicit_amount;
            mem_wgt[r_count[IW-1:0]] <= i_data.item_weight;
            mem_flr[r_count[IW-1:0]] <= i_data.floor_amount;
        end
        if (share_we) begin
            mem_share[ai] <= share_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_fixed <= n_fixed;
        r_wsum  <= n_wsum;
        r_ssum  <= n_ssum;
        r_odata <= n_odata;
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_ovalid  <= 1'b0;
            r_total   <= '0;
            r_floors  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_ovalid  <= n_ovalid;
            if (i_cfg_we && i_cfg_idx == wsa_pkg::CfgTotal) r_total <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == wsa_pkg::CfgFloors) r_floors <= i_cfg_data[0];
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

// ----- rtl/wsa_checker.sv -----
// port-level checks for the weighted share allocator
module wsa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input wsa_pkg::t_in_beat  i_data,
    input logic               o_valid,
    input logic               i_stall,
    input wsa_pkg::t_out_beat o_data
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed under stall");

    // input is refused while results are still pending
    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.last_result |-> o_stall)
        else $error("input open during emission");

    // a taken last input beat closes the input
    a_close_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.last_item |=> o_stall)
        else $error("input not closed after last beat");

    // no output right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind weighted_share_allocator wsa_checker u_wsa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
